// ===== rtl/polygon_convexity_check_core_defines.svh =====
// assertion macros for the polygon convexity checker
// used by rtl files that carry concurrent checks; needs clk and rst in scope
`ifndef POLYGON_CONVEXITY_CHECK_CORE_DEFINES_SVH
`define POLYGON_CONVEXITY_CHECK_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
// next-cycle implication
`define PCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMP(label, ante, cons)
`define PCC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/pcc_pkg.sv =====
// shared types and the orientation update for the convexity checker
// no dependencies
package pcc_pkg;

  // sign of one cross product
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  // per-beat control that travels down the pipeline
  typedef struct packed {
    logic turn_en;  // at least two vertices came before this one
    logic last;     // closing vertex
  } ctrl_t;

  // orientation tracking state
  typedef struct packed {
    logic known;    // first turn seen
    logic pos;      // first turn was strictly positive
    logic concave;  // a turn disagreed
  } orient_t;

  function automatic orient_t turn_step(input orient_t o, input sign_t s);
    orient_t r;
    r = o;
    if (!o.known) begin
      r.known = 1'b1;
      r.pos   = !s.neg && !s.zero;
    end else if (!s.zero && (s.neg == o.pos)) begin
      r.concave = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pcc_if.sv =====
// handshake channels of the convexity checker: vertex in, result out
// no dependencies
interface pcc_vertex_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pcc_result_if;
  logic valid;
  logic ready;
  logic is_convex;

  modport source (output valid, is_convex, input ready);
  modport sink   (input valid, is_convex, output ready);
endinterface

// ===== rtl/pcc_cross.sv =====
// two-stage exact cross product sign: registered products, then registered sign
// depends on pcc_pkg
module pcc_cross #(
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 ld_prod,
  input  logic                 ld_sign,
  input  logic signed [DW-1:0] e1_x,
  input  logic signed [DW-1:0] e1_y,
  input  logic signed [DW-1:0] e2_x,
  input  logic signed [DW-1:0] e2_y,
  output pcc_pkg::sign_t       sign
);
  import pcc_pkg::*;

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] prod_l;
  logic signed [PW-1:0] prod_r;
  logic        [PW:0]   diff;

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      prod_l <= e1_x * e2_y;
      prod_r <= e1_y * e2_x;
    end
  end

  assign diff = {prod_l[PW-1], prod_l} - {prod_r[PW-1], prod_r};

  always_ff @(posedge clk) begin
    if (ld_sign) begin
      sign.neg  <= diff[PW];
      sign.zero <= (diff == '0);
    end
  end

endmodule

// ===== rtl/pcc_front.sv =====
// vertex history and edge vector stage of the convexity checker
// depends on pcc_pkg
module pcc_front #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic                 in_last,
  output logic signed [CW:0]   on_x,   // newer - older
  output logic signed [CW:0]   on_y,
  output logic signed [CW:0]   nv_x,   // v - newer
  output logic signed [CW:0]   nv_y,
  output logic signed [CW:0]   vf_x,   // first - v
  output logic signed [CW:0]   vf_y,
  output logic signed [CW:0]   fs_x,   // second - first
  output logic signed [CW:0]   fs_y,
  output pcc_pkg::ctrl_t       ctrl
);
  import pcc_pkg::*;

  logic signed [CW-1:0] first_x, first_y;
  logic signed [CW-1:0] second_x, second_y;
  logic signed [CW-1:0] older_x, older_y;
  logic signed [CW-1:0] newer_x, newer_y;
  logic [1:0]           count;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x  <= '0;
      first_y  <= '0;
      second_x <= '0;
      second_y <= '0;
      older_x  <= '0;
      older_y  <= '0;
      newer_x  <= '0;
      newer_y  <= '0;
      count    <= '0;
    end else if (accept) begin
      if (in_last) begin
        first_x  <= '0;
        first_y  <= '0;
        second_x <= '0;
        second_y <= '0;
        older_x  <= '0;
        older_y  <= '0;
        newer_x  <= '0;
        newer_y  <= '0;
        count    <= '0;
      end else begin
        if (count == 2'd0) begin
          first_x <= in_x;
          first_y <= in_y;
        end
        if (count == 2'd1) begin
          second_x <= in_x;
          second_y <= in_y;
        end
        older_x <= newer_x;
        older_y <= newer_y;
        newer_x <= in_x;
        newer_y <= in_y;
        if (count != 2'd3) begin
          count <= count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      on_x         <= {newer_x[CW-1], newer_x} - {older_x[CW-1], older_x};
      on_y         <= {newer_y[CW-1], newer_y} - {older_y[CW-1], older_y};
      nv_x         <= {in_x[CW-1], in_x} - {newer_x[CW-1], newer_x};
      nv_y         <= {in_y[CW-1], in_y} - {newer_y[CW-1], newer_y};
      vf_x         <= {first_x[CW-1], first_x} - {in_x[CW-1], in_x};
      vf_y         <= {first_y[CW-1], first_y} - {in_y[CW-1], in_y};
      fs_x         <= {second_x[CW-1], second_x} - {first_x[CW-1], first_x};
      fs_y         <= {second_y[CW-1], second_y} - {first_y[CW-1], first_y};
      ctrl.turn_en <= count[1];
      ctrl.last    <= in_last;
    end
  end

endmodule

// ===== rtl/pcc_judge.sv =====
// orientation tracking and result register of the convexity checker
// depends on pcc_pkg and pcc_if
module pcc_judge (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  pcc_pkg::ctrl_t ctrl,
  input  pcc_pkg::sign_t sign_a,
  input  pcc_pkg::sign_t sign_b,
  input  pcc_pkg::sign_t sign_c,
  output logic           free,
  pcc_result_if.source   result
);
  import pcc_pkg::*;

  orient_t orient;
  orient_t orient_a;
  orient_t orient_b;
  orient_t orient_c;

  always_comb begin
    orient_a = ctrl.turn_en ? turn_step(orient, sign_a) : orient;
    orient_b = turn_step(orient_a, sign_b);
    orient_c = turn_step(orient_b, sign_c);
  end

  assign free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      orient       <= '0;
      result.valid <= 1'b0;
    end else begin
      if (go && ctrl.last) begin
        orient       <= '0;
        result.valid <= 1'b1;
      end else begin
        if (go) begin
          orient <= orient_a;
        end
        if (result.ready) begin
          result.valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.last) begin
      result.is_convex <= ctrl.turn_en && !orient_c.concave;
    end
  end

endmodule

// ===== rtl/polygon_convexity_check_core.sv =====
// polygon convexity checker: one vertex beat per cycle, one result per polygon
// the result register loads once the closing vertex beat has passed the edge, product and sign stages
// throughput: 1 vertex per cycle; a held result stalls only once the pipe fills
// reset (rst, synchronous, active high) empties the pipe and starts a new polygon
// depends on pcc_pkg, pcc_if, pcc_front, pcc_cross, pcc_judge and the defines header
`include "polygon_convexity_check_core_defines.svh"

module polygon_convexity_check_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  pcc_vertex_if.sink   vertex,
  pcc_result_if.source result
);
  import pcc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  // pipeline occupancy: s1 edge vectors, s2 products, s3 cross signs
  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3;
  logic go3;
  logic res_free;
  logic accept;

  ctrl_t s1_ctrl, s2_ctrl, s3_ctrl;

  // edge vectors of the current vertex window
  logic signed [DW-1:0] on_x, on_y, nv_x, nv_y, vf_x, vf_y, fs_x, fs_y;

  // signs of the three turns: through v, and the two closing wraparounds
  sign_t sign_a, sign_b, sign_c;

  // stage 3 retires a beat unless it is a closing beat facing a held result that is not being taken
  assign go3    = s3_valid && (!s3_ctrl.last || res_free);
  assign adv3   = !s3_valid || go3;
  assign adv2   = !s2_valid || adv3;
  assign adv1   = !s1_valid || adv2;
  assign accept = vertex.valid && adv1;

  assign vertex.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= vertex.valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // control rides alongside the payload
  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_ctrl <= s1_ctrl;
    end
    if (adv3 && s2_valid) begin
      s3_ctrl <= s2_ctrl;
    end
  end

  // vertex history and edge differences
  pcc_front #(
    .CW (COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_x    (vertex.vertex_x),
    .in_y    (vertex.vertex_y),
    .in_last (vertex.last_vertex),
    .on_x    (on_x),
    .on_y    (on_y),
    .nv_x    (nv_x),
    .nv_y    (nv_y),
    .vf_x    (vf_x),
    .vf_y    (vf_y),
    .fs_x    (fs_x),
    .fs_y    (fs_y),
    .ctrl    (s1_ctrl)
  );

  // turn (older, newer, v)
  pcc_cross #(
    .DW (DW)
  ) u_cross_a (
    .clk     (clk),
    .ld_prod (adv2 && s1_valid),
    .ld_sign (adv3 && s2_valid),
    .e1_x    (on_x),
    .e1_y    (on_y),
    .e2_x    (nv_x),
    .e2_y    (nv_y),
    .sign    (sign_a)
  );

  // turn (newer, v, first), used on the closing vertex
  pcc_cross #(
    .DW (DW)
  ) u_cross_b (
    .clk     (clk),
    .ld_prod (adv2 && s1_valid),
    .ld_sign (adv3 && s2_valid),
    .e1_x    (nv_x),
    .e1_y    (nv_y),
    .e2_x    (vf_x),
    .e2_y    (vf_y),
    .sign    (sign_b)
  );

  // turn (v, first, second), used on the closing vertex
  pcc_cross #(
    .DW (DW)
  ) u_cross_c (
    .clk     (clk),
    .ld_prod (adv2 && s1_valid),
    .ld_sign (adv3 && s2_valid),
    .e1_x    (vf_x),
    .e1_y    (vf_y),
    .e2_x    (fs_x),
    .e2_y    (fs_y),
    .sign    (sign_c)
  );

  // orientation, concavity flag and the result beat
  pcc_judge u_judge (
    .clk    (clk),
    .rst    (rst),
    .go     (go3),
    .ctrl   (s3_ctrl),
    .sign_a (sign_a),
    .sign_b (sign_b),
    .sign_c (sign_c),
    .free   (res_free),
    .result (result)
  );

  // back-pressure at the input only when every stage holds a beat
  `PCC_ASSERT_IMP(a_ready_full, !vertex.ready, s1_valid && s2_valid && s3_valid)
  // stage 3 only stalls on a closing beat behind an untaken result
  `PCC_ASSERT_IMP(a_s3_stall, s3_valid && !go3, result.valid && !result.ready && s3_ctrl.last)
  // a new result comes only from a retired closing beat
  `PCC_ASSERT_IMP(a_res_src, $rose(result.valid), $past(go3 && s3_ctrl.last))

endmodule
